[rtl/lzwd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// LZW decoder package
// Shared sizes, codes and sequencer states of the LZW decoder.
// ----------------------------------------------------------------------------
package lzwd_pkg;

    localparam int DictSize    = 4096;
    localparam int DictBits    = 12;
    localparam int MaxCodeBits = 12;
    localparam int StackDepth  = 4096;
    localparam int StackBits   = 12;

    localparam logic [12:0] CodeEnd    = 13'h100;
    localparam logic [12:0] CodeClear  = 13'h101;
    localparam logic [12:0] FirstFree  = 13'h102;
    localparam logic [12:0] FirstLimit = 13'h200;
    localparam logic [3:0]  MinBits    = 4'd9;
    localparam logic [5:0]  FeedLimit  = 6'd24;

    localparam logic REQ_FEED = 1'b0;
    localparam logic REQ_STEP = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP,
        ST_DECODE,
        ST_WALK,
        ST_WALK_WAIT,
        ST_OUT
    } lzwd_state_t;

    function automatic logic [7:0] xform(input logic [7:0] b);
        xform = {b[2:0], b[7:3]};
    endfunction

endpackage
`default_nettype wire

[rtl/lzwd_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// LZW decoder RAM
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module lzwd_ram #(
    parameter int Width = 8,
    parameter int Depth = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] addr,
    input  wire logic [Width-1:0]         wdata,
    output logic      [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

[rtl/lzw_variable_width_decoder.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// LZW variable width decoder
// Decodes a 9 to 12 bit LSB-first LZW stream, at most one output byte per step item.
// ----------------------------------------------------------------------------
// channel | direction | handshake             | payload
// in      | input     | in_valid / in_ready   | req_type, data_byte
// out     | output    | res_valid / res_ready | out_byte, out_valid, need_byte, stream_end
//
// A feed item is absorbed in ST_IDLE. A step item that pops a stacked byte passes
// through decode, stack RAM read and output (ST_DECODE, ST_POP, ST_OUT); a step
// that reads a new code first walks the dictionary chain, each link a registered
// prefix/suffix RAM read (ST_WALK, ST_WALK_WAIT), then pops.
// Reset clears all control state; the RAMs hold garbage until written.
// Input is not ready while a step is at work or its result is not yet taken.
// ----------------------------------------------------------------------------
module lzw_variable_width_decoder
    import lzwd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       req_type,
    input  wire logic [7:0] data_byte,
    output logic            res_valid,
    input  wire logic       res_ready,
    output logic [7:0]      out_byte,
    output logic            out_valid,
    output logic            need_byte,
    output logic            stream_end
);
    lzwd_state_t state_reg, state_next;
    logic [31:0] buf_reg, buf_next;
    logic [5:0]  bcnt_reg, bcnt_next;
    logic [3:0]  cw_reg, cw_next;
    logic [12:0] lim_reg, lim_next;
    logic [12:0] nfc_reg, nfc_next;
    logic [11:0] prev_reg, prev_next;
    logic [7:0]  fch_reg, fch_next;
    logic        aclr_reg, aclr_next;
    logic        fin_reg, fin_next;
    logic [12:0] sc_reg, sc_next;
    logic [11:0] cur_reg, cur_next;
    logic [11:0] code_reg, code_next;
    logic [7:0]  ob_reg, ob_next;
    logic        ov_reg, ov_next, nb_reg, nb_next, se_reg, se_next;
    logic        rv_reg, rv_next;

    logic        dict_we, stk_we;
    logic [11:0] dict_addr, stk_addr;
    logic [11:0] pre_wdata, pre_rdata;
    logic [7:0]  suf_wdata, suf_rdata, stk_wdata, stk_rdata;

    logic [11:0] cw_mask;
    logic [11:0] cur_code;
    logic        cur_big;

    lzwd_ram #(.Width(12), .Depth(DictSize)) u_prefix (
        .clk(clk), .we(dict_we), .addr(dict_addr), .wdata(pre_wdata), .rdata(pre_rdata));
    lzwd_ram #(.Width(8), .Depth(DictSize)) u_suffix (
        .clk(clk), .we(dict_we), .addr(dict_addr), .wdata(suf_wdata), .rdata(suf_rdata));
    lzwd_ram #(.Width(8), .Depth(StackDepth)) u_stack (
        .clk(clk), .we(stk_we), .addr(stk_addr), .wdata(stk_wdata), .rdata(stk_rdata));

    assign in_ready   = (state_reg == ST_IDLE) && !rv_reg;
    assign res_valid  = rv_reg;
    assign out_byte   = ob_reg;
    assign out_valid  = ov_reg;
    assign need_byte  = nb_reg;
    assign stream_end = se_reg;

    assign cw_mask  = 12'((13'd1 << cw_reg) - 13'd1);
    assign cur_code = buf_reg[11:0] & cw_mask;
    assign cur_big  = cur_reg > 12'hff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            buf_reg   <= '0;
            bcnt_reg  <= '0;
            cw_reg    <= MinBits;
            lim_reg   <= FirstLimit;
            nfc_reg   <= FirstFree;
            prev_reg  <= '0;
            fch_reg   <= '0;
            aclr_reg  <= 1'b1;
            fin_reg   <= 1'b0;
            sc_reg    <= '0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            buf_reg   <= buf_next;
            bcnt_reg  <= bcnt_next;
            cw_reg    <= cw_next;
            lim_reg   <= lim_next;
            nfc_reg   <= nfc_next;
            prev_reg  <= prev_next;
            fch_reg   <= fch_next;
            aclr_reg  <= aclr_next;
            fin_reg   <= fin_next;
            sc_reg    <= sc_next;
            rv_reg    <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        code_reg <= code_next;
        ob_reg   <= ob_next;
        ov_reg   <= ov_next;
        nb_reg   <= nb_next;
        se_reg   <= se_next;
    end

    always_comb
    begin
        state_next = state_reg;
        buf_next   = buf_reg;
        bcnt_next  = bcnt_reg;
        cw_next    = cw_reg;
        lim_next   = lim_reg;
        nfc_next   = nfc_reg;
        prev_next  = prev_reg;
        fch_next   = fch_reg;
        aclr_next  = aclr_reg;
        fin_next   = fin_reg;
        sc_next    = sc_reg;
        cur_next   = cur_reg;
        code_next  = code_reg;
        ob_next    = ob_reg;
        ov_next    = ov_reg;
        nb_next    = nb_reg;
        se_next    = se_reg;
        rv_next    = rv_reg;
        dict_we    = 1'b0;
        dict_addr  = cur_reg;
        pre_wdata  = prev_reg;
        suf_wdata  = cur_reg[7:0];
        stk_we     = 1'b0;
        stk_addr   = sc_reg[11:0];
        stk_wdata  = suf_rdata;

        if (rv_reg && res_ready)
        begin
            rv_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    if (req_type == REQ_FEED)
                    begin
                        if (bcnt_reg <= FeedLimit)
                        begin
                            buf_next  = buf_reg | (32'(data_byte) << bcnt_reg);
                            bcnt_next = bcnt_reg + 6'd8;
                        end
                    end
                    else
                    begin
                        ob_next = '0;
                        ov_next = 1'b0;
                        nb_next = 1'b0;
                        se_next = fin_reg;
                        state_next = ST_DECODE;
                    end
                end
            end
            ST_DECODE:
            begin
                // One pass of the step loop: pop, end, starve, or take a code.
                if (sc_reg != '0)
                begin
                    sc_next    = sc_reg - 13'd1;
                    stk_addr   = 12'(sc_reg - 13'd1);
                    state_next = ST_POP;
                end
                else if (fin_reg)
                begin
                    se_next    = 1'b1;
                    state_next = ST_OUT;
                end
                else if (bcnt_reg < {2'b00, cw_reg})
                begin
                    nb_next    = 1'b1;
                    state_next = ST_OUT;
                end
                else if (aclr_reg)
                begin
                    buf_next   = buf_reg >> cw_reg;
                    bcnt_next  = bcnt_reg - {2'b00, cw_reg};
                    aclr_next  = 1'b0;
                    prev_next  = cur_code;
                    fch_next   = cur_code[7:0];
                    ob_next    = xform(cur_code[7:0]);
                    ov_next    = 1'b1;
                    state_next = ST_OUT;
                end
                else if ({1'b0, cur_code} == CodeEnd)
                begin
                    fin_next   = 1'b1;
                    se_next    = 1'b1;
                    state_next = ST_OUT;
                end
                else
                begin
                    buf_next  = buf_reg >> cw_reg;
                    bcnt_next = bcnt_reg - {2'b00, cw_reg};
                    if ({1'b0, cur_code} == CodeClear)
                    begin
                        cw_next   = MinBits;
                        lim_next  = FirstLimit;
                        nfc_next  = FirstFree;
                        aclr_next = 1'b1;
                    end
                    else
                    begin
                        code_next = cur_code;
                        if ({1'b0, cur_code} >= nfc_reg)
                        begin
                            cur_next  = prev_reg;
                            stk_we    = 1'b1;
                            stk_wdata = fch_reg;
                            sc_next   = sc_reg + 13'd1;
                        end
                        else
                        begin
                            cur_next = cur_code;
                        end
                        state_next = ST_WALK;
                    end
                end
            end
            ST_WALK:
            begin
                // Chain link: read entry cur, or finish at a root byte or a full stack.
                if (cur_big && (sc_reg + 13'd1 < 13'(StackDepth)))
                begin
                    dict_addr  = cur_reg;
                    state_next = ST_WALK_WAIT;
                end
                else
                begin
                    stk_we    = 1'b1;
                    stk_wdata = cur_reg[7:0];
                    sc_next   = sc_reg + 13'd1;
                    if (nfc_reg < 13'(DictSize))
                    begin
                        dict_we   = 1'b1;
                        dict_addr = nfc_reg[11:0];
                        nfc_next  = nfc_reg + 13'd1;
                        if ((nfc_reg + 13'd1 >= lim_reg) && (cw_reg < 4'(MaxCodeBits)))
                        begin
                            cw_next  = cw_reg + 4'd1;
                            lim_next = lim_reg << 1;
                        end
                    end
                    prev_next  = code_reg;
                    fch_next   = cur_reg[7:0];
                    state_next = ST_DECODE;
                end
            end
            ST_WALK_WAIT:
            begin
                stk_we     = 1'b1;
                stk_wdata  = suf_rdata;
                sc_next    = sc_reg + 13'd1;
                cur_next   = pre_rdata;
                state_next = ST_WALK;
            end
            ST_POP:
            begin
                ob_next    = xform(stk_rdata);
                ov_next    = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                rv_next    = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !in_ready)
        else $error("input accepted while busy");
    a_one_flag: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(out_valid && need_byte))
        else $error("result carries a byte and a need flag");
    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sc_reg <= 13'(StackDepth))
        else $error("string stack overflow");
    a_width_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cw_reg >= MinBits) && (cw_reg <= 4'(MaxCodeBits)))
        else $error("code width out of range");
`endif
endmodule
`default_nettype wire

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// LZW variable width decoder testbench
// A short table of hand-packed codes runs first. Random code streams follow:
// clears, literals, dictionary hits, the KwKwK case, and the end code.
// Each step item is checked against a behavioral decoder kept in the bench, or
// against the table's expected result, with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_top;
    import lzwd_pkg::*;

    typedef struct packed {
        logic [7:0] ob;
        logic       vld;
        logic       need;
        logic       endf;
    } dec_out_t;

    typedef struct {
        logic       req;
        logic [7:0] data;
        logic       typed;
        dec_out_t   exp;
    } dir_row_t;

    localparam int WatchLimit  = 50000;
    localparam int StreamItems = 420;
    localparam dec_out_t NeedRes = '{ob: 8'h00, vld: 1'b0, need: 1'b1, endf: 1'b0};

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic       req_type;
    logic [7:0] data_byte;
    logic       res_valid;
    logic       res_ready;
    logic [7:0] out_byte;
    logic       out_valid;
    logic       need_byte;
    logic       stream_end;

    lzw_variable_width_decoder DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .data_byte  (data_byte),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .out_byte   (out_byte),
        .out_valid  (out_valid),
        .need_byte  (need_byte),
        .stream_end (stream_end)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Decoder state mirrored by the bench.
    logic [11:0]  prefix_mem [DictSize];
    logic [7:0]   suffix_mem [DictSize];
    logic [7:0]   char_stack [StackDepth];
    int unsigned  stack_cnt;
    logic [31:0]  bit_buf;
    int unsigned  buf_bits;
    int unsigned  code_bits;
    int unsigned  grow_limit;
    int unsigned  free_code;
    int unsigned  last_code;
    logic [7:0]   lead_char;
    logic         literal_next;
    logic         done;

    // Encoder side: tracks the width each emitted code is packed at.
    bit           enc_bits [$];
    int unsigned  enc_free;
    int unsigned  enc_width;
    int unsigned  enc_limit;
    logic         enc_literal;

    dec_out_t     pending_res [$];
    logic         failed;
    logic         idle_on;
    int unsigned  sent_cnt;
    int unsigned  ready_hold;
    int unsigned  quiet_cycles;

    function automatic logic [7:0] rotate3(input logic [7:0] b);
        return (b >> 3) | (b << 5);
    endfunction

    function automatic void stack_push(input logic [7:0] b);
        if (stack_cnt < StackDepth)
        begin
            char_stack[stack_cnt] = b;
            stack_cnt++;
        end
    endfunction

    function automatic void expand_code(input int unsigned code);
        int unsigned cur;
        logic [7:0]  root;
        cur = code;
        if (code >= free_code)
        begin
            cur = last_code;
            stack_push(lead_char);
        end
        while (cur > 255 && stack_cnt + 1 < StackDepth)
        begin
            stack_push(cur < DictSize ? suffix_mem[cur] : 8'h00);
            cur = cur < DictSize ? prefix_mem[cur] : 0;
        end
        root = cur[7:0];
        stack_push(root);
        if (free_code < DictSize)
        begin
            prefix_mem[free_code] = last_code[11:0];
            suffix_mem[free_code] = root;
            free_code++;
            if (free_code >= grow_limit && code_bits < MaxCodeBits)
            begin
                code_bits++;
                grow_limit = grow_limit << 1;
            end
        end
        last_code = code;
        lead_char = root;
    endfunction

    // Applies one item to the mirrored decoder; returns the step result.
    function automatic dec_out_t decode_item(input logic req, input logic [7:0] data);
        dec_out_t    r;
        int unsigned code;
        r = '0;
        if (req == REQ_FEED)
        begin
            if (buf_bits <= FeedLimit)
            begin
                bit_buf = bit_buf | (32'(data) << buf_bits);
                buf_bits += 8;
            end
            return r;
        end
        r.endf = done;
        forever
        begin
            if (stack_cnt > 0)
            begin
                stack_cnt--;
                r.ob = rotate3(char_stack[stack_cnt]);
                r.vld = 1'b1;
                return r;
            end
            if (done)
            begin
                r.endf = 1'b1;
                return r;
            end
            if (buf_bits < code_bits)
            begin
                r.need = 1'b1;
                return r;
            end
            code = bit_buf & ((32'd1 << code_bits) - 1);
            if (literal_next)
            begin
                bit_buf = bit_buf >> code_bits;
                buf_bits -= code_bits;
                literal_next = 1'b0;
                last_code = code;
                lead_char = code[7:0];
                r.ob = rotate3(lead_char);
                r.vld = 1'b1;
                return r;
            end
            if (code == CodeEnd)
            begin
                done = 1'b1;
                r.endf = 1'b1;
                return r;
            end
            bit_buf = bit_buf >> code_bits;
            buf_bits -= code_bits;
            if (code == CodeClear)
            begin
                code_bits = MinBits;
                grow_limit = FirstLimit;
                free_code = FirstFree;
                literal_next = 1'b1;
                continue;
            end
            expand_code(code);
        end
    endfunction

    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send(input logic req, input logic [7:0] data, input logic typed,
                        input dec_out_t exp);
        dec_out_t   r;
        int unsigned g;
        r = decode_item(req, data);
        if (req == REQ_STEP)
            pending_res.push_back(typed ? exp : r);
        sent_cnt++;
        if (sent_cnt % 150 == 0)
            idle_on = ($urandom_range(0, 3) != 0);
        in_valid  <= 1'b1;
        req_type  <= req;
        data_byte <= data;
        do
            @(posedge clk);
        while (!in_ready);
        g = gap_len();
        if (g > 0)
        begin
            in_valid  <= 1'b0;
            req_type  <= 1'($urandom_range(0, 1));
            data_byte <= 8'($urandom_range(0, 255));
            repeat (g) @(posedge clk);
        end
    endtask

    function automatic void emit_code(input int unsigned c);
        for (int i = 0; i < enc_width; i++)
            enc_bits.push_back(c[i]);
        if (enc_literal)
        begin
            enc_literal = 1'b0;
        end
        else if (c == CodeClear)
        begin
            enc_width   = MinBits;
            enc_limit   = FirstLimit;
            enc_free    = FirstFree;
            enc_literal = 1'b1;
        end
        else if (c != CodeEnd && enc_free < DictSize)
        begin
            enc_free++;
            if (enc_free >= enc_limit && enc_width < MaxCodeBits)
            begin
                enc_width++;
                enc_limit = enc_limit << 1;
            end
        end
    endfunction

    // Picks one well-formed code, or a literal and a clear, for the current encoder state.
    function automatic void emit_random_code(input logic allow_clear, input int lit_pct);
        int unsigned r;
        int unsigned c;
        r = $urandom_range(0, 99);
        if (enc_literal)
        begin
            // A literal of 0x100 or 0x101 is only safe when a clear follows.
            if (r < 4)
            begin
                emit_code($urandom_range(CodeEnd, CodeClear));
                emit_code(CodeClear);
            end
            else
            begin
                emit_code($urandom_range(0, 255));
            end
            return;
        end
        if (allow_clear && r < 5)
        begin
            emit_code(CodeClear);
            return;
        end
        if (r < 15 && enc_free < DictSize)
        begin
            emit_code(enc_free);
            return;
        end
        if (enc_free > FirstFree && $urandom_range(0, 99) >= lit_pct)
            c = $urandom_range(FirstFree, enc_free - 1);
        else
            c = $urandom_range(0, 255);
        emit_code(c);
    endfunction

    task automatic feed_next();
        logic [7:0] b;
        for (int i = 0; i < 8; i++)
            b[i] = enc_bits.pop_front();
        send(REQ_FEED, b, 1'b0, '0);
    endtask

    // Interleaves feeds and steps until the buffered codes are used up.
    task automatic pump();
        logic can_step;
        logic can_feed;
        forever
        begin
            can_step = stack_cnt > 0 || (!done && buf_bits >= code_bits);
            can_feed = enc_bits.size() >= 8 && buf_bits <= FeedLimit;
            if (!can_step && !can_feed)
            begin
                if ($urandom_range(0, 19) == 0)
                    send(REQ_STEP, 8'h00, 1'b0, '0);
                break;
            end
            if (can_feed && (!can_step || $urandom_range(0, 1) == 0))
                feed_next();
            else
                send(REQ_STEP, 8'($urandom_range(0, 255)), 1'b0, '0);
        end
    endtask

    task automatic random_streams(input int n);
        for (int s = 0; s < n; s++)
        begin
            idle_on = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(8, 30))
                emit_random_code(1'b1, 50);
            pump();
        end
    endtask

    // Hand-packed 9-bit codes: 0x0ff, 0x102 (KwKwK), 0x041, clear, literal
    // 0x101, clear with the literal arriving late, 0x000, 0x041.
    dir_row_t dir_rows [] = '{
        '{REQ_STEP, 8'h00, 1'b1, NeedRes},
        '{REQ_FEED, 8'hff, 1'b0, '0},
        '{REQ_STEP, 8'h00, 1'b1, NeedRes},
        '{REQ_FEED, 8'h04, 1'b0, '0},
        '{REQ_STEP, 8'h00, 1'b1, '{ob: 8'hff, vld: 1'b1, need: 1'b0, endf: 1'b0}},
        '{REQ_STEP, 8'h00, 1'b1, NeedRes},
        '{REQ_FEED, 8'h06, 1'b0, '0},
        '{REQ_FEED, 8'h09, 1'b0, '0},
        '{REQ_STEP, 8'h00, 1'b0, '0},
        '{REQ_STEP, 8'h00, 1'b0, '0},
        '{REQ_STEP, 8'h00, 1'b0, '0},
        '{REQ_STEP, 8'h00, 1'b1, NeedRes},
        '{REQ_FEED, 8'h18, 1'b0, '0},
        '{REQ_FEED, 8'h30, 1'b0, '0},
        '{REQ_FEED, 8'h20, 1'b0, '0},
        '{REQ_STEP, 8'h00, 1'b0, '0},
        '{REQ_STEP, 8'h00, 1'b1, NeedRes},
        '{REQ_FEED, 8'h80, 1'b0, '0},
        '{REQ_STEP, 8'h00, 1'b0, '0},
        '{REQ_STEP, 8'h00, 1'b1, NeedRes},
        '{REQ_FEED, 8'h20, 1'b0, '0},
        '{REQ_STEP, 8'h00, 1'b0, '0},
        '{REQ_STEP, 8'hff, 1'b1, NeedRes}
    };

    always @(posedge clk)
    begin
        if (!idle_on)
        begin
            res_ready <= 1'b1;
        end
        else if (ready_hold > 0)
        begin
            ready_hold--;
            res_ready <= 1'b0;
        end
        else if ($urandom_range(0, 99) < 70)
        begin
            res_ready <= 1'b1;
        end
        else
        begin
            res_ready <= 1'b0;
            ready_hold = ($urandom_range(0, 9) != 0) ? $urandom_range(0, 2)
                                                     : $urandom_range(10, 40);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
        begin
            if (pending_res.size() == 0)
            begin
                $display("%0t: unexpected result byte=%h valid=%b need=%b end=%b",
                         $time, out_byte, out_valid, need_byte, stream_end);
                failed = 1'b1;
            end
            else
            begin
                dec_out_t e;
                e = pending_res.pop_front();
                if (out_byte !== e.ob)
                begin
                    $display("%0t: out_byte expected %h actual %h", $time, e.ob, out_byte);
                    failed = 1'b1;
                end
                if (out_valid !== e.vld)
                begin
                    $display("%0t: out_valid expected %b actual %b", $time, e.vld, out_valid);
                    failed = 1'b1;
                end
                if (need_byte !== e.need)
                begin
                    $display("%0t: need_byte expected %b actual %b", $time, e.need, need_byte);
                    failed = 1'b1;
                end
                if (stream_end !== e.endf)
                begin
                    $display("%0t: stream_end expected %b actual %b", $time, e.endf,
                             stream_end);
                    failed = 1'b1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (res_valid && res_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WatchLimit)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        req_type     = REQ_FEED;
        data_byte    = 8'h00;
        res_ready    = 1'b0;
        failed       = 1'b0;
        idle_on      = 1'b1;
        sent_cnt     = 0;
        ready_hold   = 0;
        quiet_cycles = 0;
        stack_cnt    = 0;
        bit_buf      = '0;
        buf_bits     = 0;
        code_bits    = MinBits;
        grow_limit   = FirstLimit;
        free_code    = FirstFree;
        last_code    = 0;
        lead_char    = 8'h00;
        literal_next = 1'b1;
        done         = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send(dir_rows[i].req, dir_rows[i].data, dir_rows[i].typed, dir_rows[i].exp);

        // Encoder state matching the end of the table.
        enc_free    = FirstFree + 1;
        enc_width   = MinBits;
        enc_limit   = FirstLimit;
        enc_literal = 1'b0;

        while (sent_cnt < StreamItems)
            random_streams(1);

        // A pending literal goes first so that the end code is read as such.
        if (enc_literal)
            emit_code($urandom_range(0, 255));

        // End code, padding, then fed bytes that overflow the buffer and steps past the end.
        emit_code(CodeEnd);
        while (enc_bits.size() % 8 != 0)
            enc_bits.push_back(1'($urandom_range(0, 1)));
        pump();
        while (enc_bits.size() > 0)
            feed_next();
        repeat (6)
            send(REQ_FEED, 8'($urandom_range(0, 255)), 1'b0, '0);
        repeat (4)
            send(REQ_STEP, 8'($urandom_range(0, 255)), 1'b0, '0);
        in_valid <= 1'b0;

        while (pending_res.size() > 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (!failed)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[lzw_variable_width_decoder.f]
rtl/lzwd_pkg.sv
rtl/lzwd_ram.sv
rtl/lzw_variable_width_decoder.sv
verif/tb_top.sv
